// ===== hdl/ttq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttq_pkg: shared types for the time ordered task queue
// Opcodes, status codes, key layout and the precedence compare.
// ----------------------------------------------------------------------------
package ttq_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_LIST   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic signed [12:0] TIME_NONE = -13'sd1;

  typedef struct packed {
    logic [13:0]        year;
    logic [3:0]         month;
    logic [4:0]         day;
    logic signed [12:0] hhmm;
  } key_t;

  typedef struct packed {
    key_t prim;
    key_t fin;
  } keys_t;

  // one command word per cycle, broadcast to every cell
  typedef struct packed {
    logic ins;
    logic pop;
    logic rot;
  } cmd_t;

  // true when the new task a goes in front of stored task b
  function automatic logic precedes(input keys_t a, input keys_t b);
    logic [22:0] ad;
    logic [22:0] bd;
    logic [22:0] ae;
    logic [22:0] be;
    logic        r;
    ad = {a.prim.year, a.prim.month, a.prim.day};
    bd = {b.prim.year, b.prim.month, b.prim.day};
    ae = {a.fin.year, a.fin.month, a.fin.day};
    be = {b.fin.year, b.fin.month, b.fin.day};
    if (ad != bd) begin
      r = (ad < bd);
    end else if (a.prim.hhmm != b.prim.hhmm) begin
      r = ($signed(a.prim.hhmm) < $signed(b.prim.hhmm));
    end else if (a.prim.hhmm == TIME_NONE) begin
      r = 1'b1;
    end else if (ae != be) begin
      r = (ae < be);
    end else begin
      r = ($signed(a.fin.hhmm) < $signed(b.fin.hhmm));
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/ttq_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttq_cell: one slot of the sorted queue
// Holds a tag and its keys; compares against the incoming task and moves
// data to or from its neighbors on insert, pop and list rotation.
// ----------------------------------------------------------------------------
module ttq_cell #(
  parameter int IDX      = 0,
  parameter int CNT_W    = 5,
  parameter int TAG_BITS = 16
) (
  input  wire                       clk,
  input  wire ttq_pkg::cmd_t        cmd,
  input  wire [CNT_W-1:0]           count,
  input  wire [TAG_BITS-1:0]        new_tag,
  input  wire ttq_pkg::keys_t       new_keys,
  input  wire [TAG_BITS-1:0]        left_tag,
  input  wire ttq_pkg::keys_t       left_keys,
  input  wire [TAG_BITS-1:0]        right_tag,
  input  wire ttq_pkg::keys_t       right_keys,
  input  wire [TAG_BITS-1:0]        head_tag,
  input  wire ttq_pkg::keys_t       head_keys,
  input  wire                       hit_in,
  output logic                      hit_out,
  output logic [TAG_BITS-1:0]       tag,
  output ttq_pkg::keys_t            keys
);

  logic [TAG_BITS-1:0] tag_r;
  logic [TAG_BITS-1:0] tag_nxt;
  ttq_pkg::keys_t      keys_r;
  ttq_pkg::keys_t      keys_nxt;
  logic                occupied;
  logic                at_tail;
  logic                is_last;
  logic                hit;

  assign occupied = (count > CNT_W'(IDX));
  assign at_tail  = (count == CNT_W'(IDX));
  assign is_last  = (count == CNT_W'(IDX + 1));
  assign hit      = occupied && ttq_pkg::precedes(new_keys, keys_r);
  assign hit_out  = hit_in || hit;

  always_comb begin
    tag_nxt  = tag_r;
    keys_nxt = keys_r;
    if (cmd.ins) begin
      if (occupied || at_tail) begin
        if (hit_in) begin
          // shift toward the tail behind the insert point
          tag_nxt  = left_tag;
          keys_nxt = left_keys;
        end else if (hit || at_tail) begin
          tag_nxt  = new_tag;
          keys_nxt = new_keys;
        end
      end
    end else if (cmd.pop) begin
      tag_nxt  = right_tag;
      keys_nxt = right_keys;
    end else if (cmd.rot) begin
      // wrap the head around to the last occupied slot
      if (is_last) begin
        tag_nxt  = head_tag;
        keys_nxt = head_keys;
      end else begin
        tag_nxt  = right_tag;
        keys_nxt = right_keys;
      end
    end
  end

  always_ff @(posedge clk) begin
    tag_r  <= tag_nxt;
    keys_r <= keys_nxt;
  end

  assign tag  = tag_r;
  assign keys = keys_r;

endmodule
`default_nettype wire

// ===== hdl/time_ordered_task_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// time_ordered_task_queue: sorted insertion priority queue of task tags
// Usage: requests arrive on the in_ channel (valid/stall), results leave on
// the out_ channel (valid/stall) through one output register.
// Insert, pop and clear produce one result each; a request is taken and its
// result is valid the next cycle, so these run at one request per cycle
// while the receiver keeps up.
// List produces one result per stored task (or one empty result): after the
// request is taken the queue rotates one slot per cycle through the cell
// chain while the receiver keeps up, emitting the head on each rotation, and
// in_stall stays high until the last tag has been registered.
// Insert searches all slots at once; the precedence flag ripples along the
// chain of cells, which sets the insert path length.
// A stalled receiver holds the output register and back-pressures the input.
// Reset empties the queue and drops any pending result; slot contents are not
// cleared.
// ----------------------------------------------------------------------------
module time_ordered_task_queue #(
  parameter int DEPTH    = 16,
  parameter int TAG_BITS = 16
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire [1:0]            in_opcode,
  input  wire [TAG_BITS-1:0]   in_task_tag,
  input  wire                  in_is_deadline,
  input  wire [13:0]           in_key_year,
  input  wire [3:0]            in_key_month,
  input  wire [4:0]            in_key_day,
  input  wire signed [12:0]    in_key_time,
  input  wire [13:0]           in_end_year,
  input  wire [3:0]            in_end_month,
  input  wire [4:0]            in_end_day,
  input  wire signed [12:0]    in_end_time,
  output logic                 out_valid,
  input  wire                  out_stall,
  output logic [1:0]           out_status,
  output logic [TAG_BITS-1:0]  out_tag,
  output logic [4:0]           out_entry_count,
  output logic                 out_last_item
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    count_nxt;
  logic [CNT_W-1:0]    rem_r;
  logic [CNT_W-1:0]    rem_nxt;
  logic                busy_r;
  logic                busy_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic [1:0]          out_status_r;
  logic [1:0]          out_status_nxt;
  logic [TAG_BITS-1:0] out_tag_r;
  logic [TAG_BITS-1:0] out_tag_nxt;
  logic [CNT_W-1:0]    out_count_r;
  logic [CNT_W-1:0]    out_count_nxt;
  logic                out_last_r;
  logic                out_last_nxt;
  logic [31:0]         out_count_ext;

  logic                out_free;
  logic                acc;
  logic                full;
  logic                empty;
  logic                produce;
  ttq_pkg::cmd_t       cmd;
  ttq_pkg::keys_t      new_keys;

  logic [TAG_BITS-1:0] cell_tag  [DEPTH];
  ttq_pkg::keys_t      cell_keys [DEPTH];
  logic [DEPTH:0]      hit;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = busy_r || !out_free;
  assign acc      = in_valid && !in_stall;
  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);

  always_comb begin
    new_keys.prim.year  = in_key_year;
    new_keys.prim.month = in_key_month;
    new_keys.prim.day   = in_key_day;
    new_keys.prim.hhmm  = in_key_time;
    if (in_is_deadline) begin
      new_keys.fin.year  = '0;
      new_keys.fin.month = '0;
      new_keys.fin.day   = '0;
      new_keys.fin.hhmm  = ttq_pkg::TIME_NONE;
    end else begin
      new_keys.fin.year  = in_end_year;
      new_keys.fin.month = in_end_month;
      new_keys.fin.day   = in_end_day;
      new_keys.fin.hhmm  = in_end_time;
    end
  end

  assign cmd.ins = acc && (in_opcode == ttq_pkg::OP_INSERT) && !full;
  assign cmd.pop = acc && (in_opcode == ttq_pkg::OP_POP) && !empty;
  assign cmd.rot = busy_r && out_free;

  assign hit[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [TAG_BITS-1:0] l_tag;
    ttq_pkg::keys_t      l_keys;
    logic [TAG_BITS-1:0] r_tag;
    ttq_pkg::keys_t      r_keys;

    if (i == 0) begin : g_first
      assign l_tag  = in_task_tag;
      assign l_keys = new_keys;
    end else begin : g_mid_l
      assign l_tag  = cell_tag[i-1];
      assign l_keys = cell_keys[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign r_tag  = cell_tag[i];
      assign r_keys = cell_keys[i];
    end else begin : g_mid_r
      assign r_tag  = cell_tag[i+1];
      assign r_keys = cell_keys[i+1];
    end

    ttq_cell #(
      .IDX      (i),
      .CNT_W    (CNT_W),
      .TAG_BITS (TAG_BITS)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .count      (count_r),
      .new_tag    (in_task_tag),
      .new_keys   (new_keys),
      .left_tag   (l_tag),
      .left_keys  (l_keys),
      .right_tag  (r_tag),
      .right_keys (r_keys),
      .head_tag   (cell_tag[0]),
      .head_keys  (cell_keys[0]),
      .hit_in     (hit[i]),
      .hit_out    (hit[i+1]),
      .tag        (cell_tag[i]),
      .keys       (cell_keys[i])
    );
  end

  always_comb begin
    count_nxt      = count_r;
    rem_nxt        = rem_r;
    busy_nxt       = busy_r;
    produce        = 1'b0;
    out_status_nxt = out_status_r;
    out_tag_nxt    = out_tag_r;
    out_count_nxt  = out_count_r;
    out_last_nxt   = out_last_r;

    if (busy_r) begin
      if (out_free) begin
        produce        = 1'b1;
        out_status_nxt = ttq_pkg::ST_OK;
        out_tag_nxt    = cell_tag[0];
        out_count_nxt  = count_r;
        out_last_nxt   = (rem_r == CNT_W'(1));
        rem_nxt        = rem_r - CNT_W'(1);
        if (rem_r == CNT_W'(1)) begin
          busy_nxt = 1'b0;
        end
      end
    end else if (acc) begin
      out_status_nxt = ttq_pkg::ST_OK;
      out_tag_nxt    = '0;
      out_last_nxt   = 1'b1;
      produce        = 1'b1;
      case (in_opcode)
        ttq_pkg::OP_INSERT: begin
          if (full) begin
            out_status_nxt = ttq_pkg::ST_FULL;
          end else begin
            count_nxt = count_r + CNT_W'(1);
          end
        end
        ttq_pkg::OP_POP: begin
          if (empty) begin
            out_status_nxt = ttq_pkg::ST_EMPTY;
          end else begin
            out_tag_nxt = cell_tag[0];
            count_nxt   = count_r - CNT_W'(1);
          end
        end
        ttq_pkg::OP_CLEAR: begin
          count_nxt = '0;
        end
        ttq_pkg::OP_LIST: begin
          if (empty) begin
            out_status_nxt = ttq_pkg::ST_EMPTY;
          end else begin
            // hold the result until the rotation emits each tag
            produce  = 1'b0;
            busy_nxt = 1'b1;
            rem_nxt  = count_r;
          end
        end
        default: begin
          produce = 1'b0;
        end
      endcase
      out_count_nxt = count_nxt;
    end

    out_valid_nxt = produce || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      rem_r       <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      rem_r       <= rem_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      out_status_r <= out_status_nxt;
      out_tag_r    <= out_tag_nxt;
      out_count_r  <= out_count_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  assign out_count_ext   = 32'(out_count_r);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_tag         = out_tag_r;
  assign out_entry_count = out_count_ext[4:0];
  assign out_last_item   = out_last_r;

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("stored count exceeds depth");

  a_list_starts : assert property (@(posedge clk) disable iff (!rst_n)
    acc && (in_opcode == ttq_pkg::OP_LIST) && !empty |=> busy_r && !out_valid)
    else $error("list request did not start rotation");

  a_busy_rem : assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (rem_r != '0) && (rem_r <= count_r))
    else $error("list remainder out of range while busy");

  a_pop_dec : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("pop did not decrement count");

  a_list_end : assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && out_free && (rem_r == CNT_W'(1)) |=> !busy_r && out_valid && out_last_item)
    else $error("list did not end on last item");

endmodule
`default_nettype wire
